// ===== rtl/cbe_pkg.sv =====
// Package for the configurable CRC byte engine.
// Holds register indexes, reset values, the configuration struct and a byte reversal.
// No dependencies.
package cbe_pkg;

    localparam int DEF_MAX_WIDTH = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int REG_BITS      = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CRC_WIDTH   = 3'd0,
        REG_POLYNOMIAL  = 3'd1,
        REG_INIT_VALUE  = 3'd2,
        REG_FINAL_XOR   = 3'd3,
        REG_REFLECT_IN  = 3'd4,
        REG_REFLECT_OUT = 3'd5
    } t_cfg_reg;

    localparam logic [5:0]          RST_CRC_WIDTH   = 6'd32;
    localparam logic [REG_BITS-1:0] RST_POLYNOMIAL  = 32'h04C1_1DB7;
    localparam logic [REG_BITS-1:0] RST_INIT_VALUE  = 32'hFFFF_FFFF;
    localparam logic [REG_BITS-1:0] RST_FINAL_XOR   = 32'hFFFF_FFFF;
    localparam logic                RST_REFLECT_IN  = 1'b1;
    localparam logic                RST_REFLECT_OUT = 1'b1;

    typedef struct packed {
        logic [5:0]          crc_width;
        logic [REG_BITS-1:0] polynomial;
        logic [REG_BITS-1:0] init_value;
        logic [REG_BITS-1:0] final_xor;
        logic                reflect_in;
        logic                reflect_out;
    } t_cfg;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

// ===== rtl/cbe_core.sv =====
// Combinational byte update for the CRC engine: align, eight division steps, finish.
// Depends on cbe_pkg for the configuration struct and byte reversal.
module cbe_core #(
    parameter int P_MAX_WIDTH = cbe_pkg::DEF_MAX_WIDTH
) (
    input  cbe_pkg::t_cfg           i_cfg,
    input  logic                    i_start,
    input  logic [7:0]              i_data,
    input  logic [P_MAX_WIDTH-1:0]  i_rem,
    output logic [P_MAX_WIDTH-1:0]  o_rem,
    output logic [31:0]             o_crc
);
    import cbe_pkg::*;

    localparam int MAXW    = P_MAX_WIDTH;
    localparam int SH_BITS = (MAXW > 8) ? $clog2(MAXW) : 1;

    logic [7:0]         w_eff;
    logic [7:0]         sh_full;
    logic [SH_BITS-1:0] sh;
    logic [MAXW-1:0]    mask;
    logic [MAXW-1:0]    poly_al;
    logic [MAXW-1:0]    init_ext;
    logic [MAXW-1:0]    fxor_ext;
    logic [7:0]         din;
    logic [MAXW-1:0]    rem;
    logic [MAXW-1:0]    rem_rev;
    logic [MAXW-1:0]    fin;

    always_comb begin
        w_eff = {2'b00, i_cfg.crc_width};
        if (w_eff < 8'd8) begin
            w_eff = 8'd8;
        end else if (w_eff > 8'(MAXW)) begin
            w_eff = 8'(MAXW);
        end
        sh_full = 8'(MAXW) - w_eff;
        sh      = SH_BITS'(sh_full);
    end

    assign mask     = {MAXW{1'b1}} >> sh;
    assign poly_al  = MAXW'({{MAXW{1'b0}}, i_cfg.polynomial}) << sh;
    assign init_ext = MAXW'({{MAXW{1'b0}}, i_cfg.init_value});
    assign fxor_ext = MAXW'({{MAXW{1'b0}}, i_cfg.final_xor});
    assign din      = i_cfg.reflect_in ? rev8(i_data) : i_data;

    always_comb begin
        rem = (i_start ? init_ext : i_rem) << sh;
        rem = rem ^ (MAXW'(din) << (MAXW - 8));
        for (int i = 0; i < 8; i++) begin
            rem = rem[MAXW-1] ? ((rem << 1) ^ poly_al) : (rem << 1);
        end
    end

    always_comb begin
        for (int i = 0; i < MAXW; i++) begin
            rem_rev[i] = rem[MAXW-1-i];
        end
    end

    assign o_rem = rem >> sh;
    assign fin   = ((i_cfg.reflect_out ? rem_rev : (rem >> sh)) ^ fxor_ext) & mask;
    assign o_crc = 32'({32'b0, fin});

endmodule

// ===== rtl/configurable_crc_byte_engine.sv =====
// Top level of the configurable CRC byte engine: config registers, item and result registers.
// Depends on cbe_pkg and cbe_core.
//
//   channel | direction | handshake                      | payload
//   --------+-----------+--------------------------------+------------------------------
//   in      | in        | i_in_valid / o_in_ready        | i_data_byte, i_last_byte
//   out     | out       | o_out_valid / i_out_ready      | o_crc_value
//   cfg     | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One byte per cycle while the input is not stalled; a last byte is held in the item register,
// then its result in the result register. The eight-step division in cbe_core between them
// sets the cycle. A waiting result stalls the input only when the held byte is a last byte.
// Reset is synchronous, active low, and restores the standard CRC-32 settings.
module configurable_crc_byte_engine #(
    parameter int P_MAX_WIDTH = cbe_pkg::DEF_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_last_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [31:0]                        o_crc_value,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cbe_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [cbe_pkg::REG_BITS-1:0]       i_cfg_data
);
    import cbe_pkg::*;

    t_cfg                   r_cfg;
    logic                   r_in_valid;
    logic [7:0]             r_in_data;
    logic                   r_in_last;
    logic [P_MAX_WIDTH-1:0] r_rem;
    logic                   r_in_msg;
    logic                   r_out_valid;
    logic [31:0]            r_out_crc;

    logic                   advance;
    logic [P_MAX_WIDTH-1:0] n_rem;
    logic [31:0]            n_crc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_width   <= RST_CRC_WIDTH;
            r_cfg.polynomial  <= RST_POLYNOMIAL;
            r_cfg.init_value  <= RST_INIT_VALUE;
            r_cfg.final_xor   <= RST_FINAL_XOR;
            r_cfg.reflect_in  <= RST_REFLECT_IN;
            r_cfg.reflect_out <= RST_REFLECT_OUT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CRC_WIDTH:   r_cfg.crc_width   <= i_cfg_data[5:0];
                REG_POLYNOMIAL:  r_cfg.polynomial  <= i_cfg_data;
                REG_INIT_VALUE:  r_cfg.init_value  <= i_cfg_data;
                REG_FINAL_XOR:   r_cfg.final_xor   <= i_cfg_data;
                REG_REFLECT_IN:  r_cfg.reflect_in  <= i_cfg_data[0];
                REG_REFLECT_OUT: r_cfg.reflect_out <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    cbe_core #(
        .P_MAX_WIDTH(P_MAX_WIDTH)
    ) u_core (
        .i_cfg  (r_cfg),
        .i_start(!r_in_msg),
        .i_data (r_in_data),
        .i_rem  (r_rem),
        .o_rem  (n_rem),
        .o_crc  (n_crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_in_msg <= 1'b0;
        end else if (advance) begin
            r_rem    <= n_rem;
            r_in_msg <= !r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_crc <= n_crc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_out_crc;

endmodule

// ===== rtl/cbe_checker.sv =====
// Port-level checks for the configurable CRC byte engine, bound to its top level.
// Imports cbe_pkg; its port widths are written out in the ports.
module cbe_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [31:0]                       o_crc_value,
    input logic                              o_cfg_ready
);
    import cbe_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_crc_value))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready && o_cfg_ready)
        else $error("input blocked with empty result register");

endmodule

bind configurable_crc_byte_engine cbe_checker u_cbe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_crc_value(o_crc_value),
    .o_cfg_ready(o_cfg_ready)
);

// ===== tb/testbench.sv =====
// Self-checking bench for configurable_crc_byte_engine: directed rows, then random messages.
// Keeps its own byte-wise CRC predictor and configuration copy; depends on cbe_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cbe_pkg::*;

    localparam int                      CYCLE_LIMIT  = 400000;
    localparam int                      RAND_ITEMS   = 1900;
    localparam int                      CALM_ITEMS   = 300;
    localparam int                      DRAIN_CYCLES = 4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                    is_cfg;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [31:0]             val;
        logic [7:0]              data;
        logic                    last;
        logic                    typed;
        logic [31:0]             crc;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [7:0]              i_data_byte = '0;
    logic                    i_last_byte = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [31:0]             o_crc_value;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [REG_BITS-1:0]     i_cfg_data = '0;

    t_cfg        model_cfg;
    logic [31:0] model_rem;
    bit          model_open;
    logic [31:0] crc_expect_q[$];
    t_row        dir_rows[$];
    logic [31:0] crc_want;
    int          err_cnt = 0;
    int          cycle_cnt = 0;
    int          stall_cnt = 0;
    int          sent = 0;
    bit          idle_on = 1'b1;

    configurable_crc_byte_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_crc_value (o_crc_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [63:0] flip_low(input logic [63:0] v, input int n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++) begin
            r[i] = v[n-1-i];
        end
        return r;
    endfunction

    function automatic void crc_model_step(input logic [7:0] b, input logic is_last,
                                           output bit produced, output logic [31:0] crc);
        int          w;
        logic [63:0] mask;
        logic [63:0] poly;
        logic [63:0] rem;
        logic [63:0] d;
        logic [63:0] v;
        logic        top;
        w = model_cfg.crc_width;
        if (w < 8) w = 8;
        if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
        mask = (64'd1 << w) - 64'd1;
        poly = {32'd0, model_cfg.polynomial} & mask;
        if (!model_open) model_rem = model_cfg.init_value & mask[31:0];
        rem = {32'd0, model_rem} & mask;
        d = {56'd0, b};
        if (model_cfg.reflect_in) d = flip_low(d, 8);
        rem = rem ^ (d << (w - 8));
        for (int i = 0; i < 8; i++) begin
            top = rem[w-1];
            rem = (rem << 1) & mask;
            if (top) rem = rem ^ poly;
        end
        model_rem = rem[31:0];
        produced = is_last;
        crc = '0;
        if (is_last) begin
            v = model_cfg.reflect_out ? flip_low(rem, w) : rem;
            v = (v ^ {32'd0, model_cfg.final_xor}) & mask;
            crc = v[31:0];
            model_open = 1'b0;
        end else begin
            model_open = 1'b1;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last,
                             input logic typed, input logic [31:0] typed_crc);
        bit          produced;
        logic [31:0] crc;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        do @(posedge i_clk); while (!o_in_ready);
        crc_model_step(b, is_last, produced, crc);
        if (produced) crc_expect_q.push_back(typed ? typed_crc : crc);
        sent++;
    endtask

    // Hold valid high across back-to-back writes; the caller drops it afterwards.
    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_CRC_WIDTH:   model_cfg.crc_width   = val[5:0];
            REG_POLYNOMIAL:  model_cfg.polynomial  = val;
            REG_INIT_VALUE:  model_cfg.init_value  = val;
            REG_FINAL_XOR:   model_cfg.final_xor   = val;
            REG_REFLECT_IN:  model_cfg.reflect_in  = val[0];
            REG_REFLECT_OUT: model_cfg.reflect_out = val[0];
            default: ;
        endcase
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (crc_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        dir_rows.push_back('{1'b1, idx, val, 8'd0, 1'b0, 1'b0, 32'd0});
    endtask

    task automatic add_byte(input logic [7:0] b, input logic is_last,
                            input logic typed, input logic [31:0] crc);
        dir_rows.push_back('{1'b0, '0, 32'd0, b, is_last, typed, crc});
    endtask

    task automatic add_check_string(input logic [31:0] crc);
        for (int i = 1; i <= 9; i++) begin
            add_byte(8'h30 + 8'(i), i == 9, i == 9, crc);
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_width();
        logic [31:0] noise;
        noise = $urandom() & ~32'h3F;
        case ($urandom_range(0, 7))
            0:       return noise | 32'd8;
            1:       return noise | 32'd32;
            2:       return noise | $urandom_range(0, 7);
            3:       return noise | $urandom_range(33, 63);
            default: return noise | $urandom_range(8, 32);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_cnt   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (crc_expect_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("unexpected crc result %h", o_crc_value);
                end else begin
                    crc_want = crc_expect_q.pop_front();
                    if (o_crc_value !== crc_want) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("crc mismatch: expected %h got %h", crc_want, o_crc_value);
                        end
                    end
                end
            end
            if (stall_cnt != 0) begin
                stall_cnt <= stall_cnt - 1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                stall_cnt   <= $urandom_range(0, 8);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int  budget;
        int  len;
        bit  prev_cfg;
        model_cfg  = '{RST_CRC_WIDTH, RST_POLYNOMIAL, RST_INIT_VALUE, RST_FINAL_XOR,
                       RST_REFLECT_IN, RST_REFLECT_OUT};
        model_rem  = '0;
        model_open = 1'b0;

        add_check_string(32'hCBF4_3926);
        add_cfg(REG_CRC_WIDTH, 32'd16);
        add_cfg(REG_POLYNOMIAL, 32'h0000_1021);
        add_cfg(REG_INIT_VALUE, 32'h0000_FFFF);
        add_cfg(REG_FINAL_XOR, 32'h0000_0000);
        add_cfg(REG_REFLECT_IN, 32'd0);
        add_cfg(REG_REFLECT_OUT, 32'd0);
        add_check_string(32'h0000_29B1);
        add_cfg(REG_CRC_WIDTH, 32'd0);
        add_cfg(REG_POLYNOMIAL, 32'h0000_0000);
        add_cfg(REG_INIT_VALUE, 32'h0000_0000);
        add_cfg(REG_FINAL_XOR, 32'hFFFF_FFFF);
        add_byte(8'hFF, 1'b1, 1'b1, 32'h0000_00FF);
        add_cfg(REG_CRC_WIDTH, 32'hFFFF_FFFF);
        add_cfg(REG_POLYNOMIAL, 32'hFFFF_FFFF);
        add_cfg(REG_INIT_VALUE, 32'hFFFF_FFFF);
        add_cfg(REG_FINAL_XOR, 32'h0000_0000);
        add_cfg(REG_REFLECT_IN, 32'hFFFF_FFFF);
        add_cfg(REG_REFLECT_OUT, 32'h0000_0001);
        add_byte(8'h00, 1'b0, 1'b0, '0);
        add_byte(8'hFF, 1'b1, 1'b0, '0);
        add_byte(8'h5A, 1'b0, 1'b0, '0);
        add_cfg(REG_CRC_WIDTH, 32'd8);
        add_byte(8'hA5, 1'b1, 1'b0, '0);
        add_cfg(REG_SPARE_LO, 32'hFFFF_FFFF);
        add_cfg(REG_SPARE_HI, 32'h0000_0000);
        add_byte(8'h00, 1'b1, 1'b0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                if (!prev_cfg) settle();
                cfg_write(dir_rows[k].idx, dir_rows[k].val);
            end else begin
                if (prev_cfg) i_cfg_valid <= 1'b0;
                send_byte(dir_rows[k].data, dir_rows[k].last, dir_rows[k].typed,
                          dir_rows[k].crc);
            end
            prev_cfg = dir_rows[k].is_cfg;
        end

        sent = 0;
        while (sent < RAND_ITEMS) begin
            settle();
            idle_on = ($urandom_range(0, 3) != 0) && (sent < RAND_ITEMS - CALM_ITEMS);
            if ($urandom_range(0, 1)) cfg_write(REG_CRC_WIDTH, pick_width());
            if ($urandom_range(0, 1)) cfg_write(REG_POLYNOMIAL, pick_word());
            if ($urandom_range(0, 1)) cfg_write(REG_INIT_VALUE, pick_word());
            if ($urandom_range(0, 1)) cfg_write(REG_FINAL_XOR, pick_word());
            if ($urandom_range(0, 1)) cfg_write(REG_REFLECT_IN, $urandom());
            if ($urandom_range(0, 1)) cfg_write(REG_REFLECT_OUT, $urandom());
            if ($urandom_range(0, 7) == 0) begin
                cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
            end
            i_cfg_valid <= 1'b0;
            budget = $urandom_range(40, 120);
            while (budget > 0 && sent < RAND_ITEMS) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                for (int j = 0; j < len && budget > 0 && sent < RAND_ITEMS; j++) begin
                    send_byte(8'($urandom()), j == len - 1, 1'b0, '0);
                    budget--;
                end
            end
        end

        settle();
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
